FILE: hdl/nbaer_pkg.sv
// nbaer_pkg: shared types, widths, arctangent table and CORDIC gain helper
// for the NED-to-body azimuth/elevation/range pipeline. No dependencies.
package nbaer_pkg;

  localparam int W      = 42;   // datapath width, Q.12 metres plus growth
  localparam int LO_W   = 21;   // low slice of a compensation multiply
  localparam int HI_W   = W - LO_W;
  localparam int INVK_W = 24;   // inverse gain, Q.24
  localparam int ZW     = 34;   // angle accumulator width
  localparam int GUARD  = 4;

  typedef logic signed [W-1:0]  vec_t;
  typedef logic        [31:0]   ang_t;
  typedef logic signed [ZW-1:0] zacc_t;

  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // CORDIC gain K in Q.30 for n stages (elaboration only)
  function automatic longint unsigned gain_root(input int n);
    longint unsigned p;
    longint unsigned v;
    longint unsigned res;
    longint unsigned bitv;
    p = 64'd1 << 60;
    for (int i = 0; i < n; i++) begin
      p = p + (p >> (2 * i));
    end
    v = p;
    res = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

endpackage

FILE: hdl/nbaer_cordic.sv
// nbaer_cordic: pipelined CORDIC, rotation or vectoring mode, one stage per
// iteration plus quadrant pre-step and a two-stage gain compensation.
// Depends on nbaer_pkg.
module nbaer_cordic #(
  parameter int STAGES    = 16,
  parameter bit VECTORING = 1'b0,
  parameter int SIDE_W    = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  nbaer_pkg::vec_t     in_x,
  input  nbaer_pkg::vec_t     in_y,
  input  nbaer_pkg::ang_t     in_ang,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output nbaer_pkg::vec_t     out_x,
  output nbaer_pkg::vec_t     out_y,
  output nbaer_pkg::ang_t     out_ang,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int W      = nbaer_pkg::W;
  localparam int LO_W   = nbaer_pkg::LO_W;
  localparam int HI_W   = nbaer_pkg::HI_W;
  localparam int INVK_W = nbaer_pkg::INVK_W;
  localparam int ZW     = nbaer_pkg::ZW;
  localparam int PL_W   = LO_W + INVK_W + 2;
  localparam int PH_W   = HI_W + INVK_W + 1;
  localparam int SUM_W  = W + INVK_W + 1;

  localparam longint unsigned K_RAW  = nbaer_pkg::gain_root(STAGES);
  localparam longint unsigned K      = (K_RAW == 64'd0) ? 64'd1 : K_RAW;
  localparam longint unsigned INVK_L = ((64'd1 << 54) + (K >> 1)) / K;
  localparam logic signed [INVK_W:0] INVK = {1'b0, INVK_L[INVK_W-1:0]};
  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(64'd1 << 23);

  nbaer_pkg::vec_t    xs_r [0:STAGES];
  nbaer_pkg::vec_t    ys_r [0:STAGES];
  nbaer_pkg::zacc_t   zs_r [0:STAGES];
  logic [SIDE_W-1:0]  sd_r [0:STAGES];
  logic               zf_r [0:STAGES];
  logic               vl_r [0:STAGES];

  // quadrant pre-step
  logic            pre_neg;
  nbaer_pkg::ang_t pre_ang;
  always_comb begin
    if (VECTORING) begin
      pre_neg = in_x[W-1];
    end else begin
      pre_neg = (in_ang[31:30] == 2'b01) || (in_ang[31:30] == 2'b10);
    end
    pre_ang = in_ang + (pre_neg ? 32'h8000_0000 : 32'h0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r[0] <= 1'b0;
    end else begin
      vl_r[0] <= in_valid;
    end
    xs_r[0] <= pre_neg ? -in_x : in_x;
    ys_r[0] <= pre_neg ? -in_y : in_y;
    zs_r[0] <= ZW'($signed(pre_ang));
    sd_r[0] <= in_side;
    zf_r[0] <= (in_x == '0) && (in_y == '0);
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam nbaer_pkg::zacc_t AT = {2'b00, nbaer_pkg::ATAN_TAB[i]};
    logic            dir;
    nbaer_pkg::vec_t dx;
    nbaer_pkg::vec_t dy;
    always_comb begin
      dir = VECTORING ? !ys_r[i][W-1] : !zs_r[i][ZW-1];
      dx  = ys_r[i] >>> i;
      dy  = xs_r[i] >>> i;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[i+1] <= 1'b0;
      end else begin
        vl_r[i+1] <= vl_r[i];
      end
      if (VECTORING == dir) begin
        xs_r[i+1] <= xs_r[i] + dx;
        ys_r[i+1] <= ys_r[i] - dy;
      end else begin
        xs_r[i+1] <= xs_r[i] - dx;
        ys_r[i+1] <= ys_r[i] + dy;
      end
      zs_r[i+1] <= (VECTORING == dir) ? zs_r[i] + AT : zs_r[i] - AT;
      sd_r[i+1] <= sd_r[i];
      zf_r[i+1] <= zf_r[i];
    end
  end

  // gain compensation: split products, then sum and round
  logic signed [PL_W-1:0] xlo_r, ylo_r;
  logic signed [PH_W-1:0] xhi_r, yhi_r;
  nbaer_pkg::zacc_t       za_r;
  logic [SIDE_W-1:0]      sa_r;
  logic                   zfa_r, va_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= vl_r[STAGES];
    end
    xlo_r <= $signed({1'b0, xs_r[STAGES][LO_W-1:0]}) * INVK;
    ylo_r <= $signed({1'b0, ys_r[STAGES][LO_W-1:0]}) * INVK;
    xhi_r <= $signed(xs_r[STAGES][W-1:LO_W]) * INVK;
    yhi_r <= $signed(ys_r[STAGES][W-1:LO_W]) * INVK;
    za_r  <= zs_r[STAGES];
    sa_r  <= sd_r[STAGES];
    zfa_r <= zf_r[STAGES];
  end

  logic signed [SUM_W-1:0] xsum, ysum;
  always_comb begin
    xsum = (SUM_W'(xhi_r) <<< LO_W) + SUM_W'(xlo_r) + ROUND;
    ysum = (SUM_W'(yhi_r) <<< LO_W) + SUM_W'(ylo_r) + ROUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= va_r;
    end
    out_x    <= xsum[INVK_W +: W];
    out_y    <= ysum[INVK_W +: W];
    out_ang  <= (VECTORING && zfa_r) ? 32'h0 : za_r[31:0];
    out_side <= sa_r;
  end

endmodule

FILE: hdl/ned_to_body_az_el_range.sv
// ned_to_body_az_el_range: NED relative position to body-frame azimuth,
// elevation and slant range; five chained CORDIC pipelines.
// Depends on nbaer_pkg and nbaer_cordic.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+---------------------------
//  request | in_* (positions, roll/pitch/yaw)   | start high, busy low
//  result  | out_azimuth/elevation/slant_range  | out_valid, one cycle only
//
// One request per cycle; busy is always low. The datapath is a difference
// register, then the three rotation and two vectoring pipelines of
// CORDIC_STAGES iteration stages each, then an output register.
// Reset clears the valid bits only. Results cannot be held off.
module ned_to_body_az_el_range #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_target_north,
  input  logic signed [31:0] in_target_east,
  input  logic signed [31:0] in_target_down,
  input  logic signed [31:0] in_own_north,
  input  logic signed [31:0] in_own_east,
  input  logic signed [31:0] in_own_down,
  input  logic signed [15:0] in_own_roll,
  input  logic signed [15:0] in_own_pitch,
  input  logic signed [15:0] in_own_yaw,
  output logic               out_valid,
  output logic signed [15:0] out_azimuth,
  output logic signed [15:0] out_elevation,
  output logic        [33:0] out_slant_range
);

  localparam int W = nbaer_pkg::W;

  assign busy = 1'b0;

  // difference stage
  nbaer_pkg::vec_t bx_r, by_r, bz_r;
  logic [15:0]     roll_r, pitch_r, yaw_r;
  logic            d_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= start;
    end
    bx_r <= (W'(in_target_north) - W'(in_own_north)) <<< nbaer_pkg::GUARD;
    by_r <= (W'(in_target_east) - W'(in_own_east)) <<< nbaer_pkg::GUARD;
    bz_r <= (W'(in_target_down) - W'(in_own_down)) <<< nbaer_pkg::GUARD;
    roll_r  <= in_own_roll;
    pitch_r <= in_own_pitch;
    yaw_r   <= in_own_yaw;
  end

  // rotation by -yaw on (north, east)
  logic            r1_valid;
  nbaer_pkg::vec_t r1_x, r1_y;
  nbaer_pkg::ang_t r1_ang;
  logic [W+31:0]   r1_side;

  nbaer_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0), .SIDE_W(W + 32)) u_rot_yaw (
    .clk(clk), .rst_n(rst_n), .in_valid(d_valid_r),
    .in_x(bx_r), .in_y(by_r), .in_ang(32'h0 - {yaw_r, 16'h0}),
    .in_side({bz_r, pitch_r, roll_r}),
    .out_valid(r1_valid), .out_x(r1_x), .out_y(r1_y), .out_ang(r1_ang),
    .out_side(r1_side)
  );

  // rotation by +pitch on (x, down)
  logic            r2_valid;
  nbaer_pkg::vec_t r2_x, r2_y;
  nbaer_pkg::ang_t r2_ang;
  logic [W+15:0]   r2_side;

  nbaer_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0), .SIDE_W(W + 16)) u_rot_pitch (
    .clk(clk), .rst_n(rst_n), .in_valid(r1_valid),
    .in_x(r1_x), .in_y(r1_side[W+31:32]), .in_ang({r1_side[31:16], 16'h0}),
    .in_side({r1_y, r1_side[15:0]}),
    .out_valid(r2_valid), .out_x(r2_x), .out_y(r2_y), .out_ang(r2_ang),
    .out_side(r2_side)
  );

  // rotation by -roll on (y, down)
  logic            r3_valid;
  nbaer_pkg::vec_t r3_x, r3_y;
  nbaer_pkg::ang_t r3_ang;
  nbaer_pkg::vec_t r3_side;

  nbaer_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b0), .SIDE_W(W)) u_rot_roll (
    .clk(clk), .rst_n(rst_n), .in_valid(r2_valid),
    .in_x(r2_side[W+15:16]), .in_y(r2_y), .in_ang(32'h0 - {r2_side[15:0], 16'h0}),
    .in_side(r2_x),
    .out_valid(r3_valid), .out_x(r3_x), .out_y(r3_y), .out_ang(r3_ang),
    .out_side(r3_side)
  );

  // azimuth and horizontal magnitude
  logic            v1_valid;
  nbaer_pkg::vec_t v1_x, v1_y;
  nbaer_pkg::ang_t v1_ang;
  nbaer_pkg::vec_t v1_side;

  nbaer_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b1), .SIDE_W(W)) u_vec_az (
    .clk(clk), .rst_n(rst_n), .in_valid(r3_valid),
    .in_x(r3_side), .in_y(r3_x), .in_ang(32'h0), .in_side(r3_y),
    .out_valid(v1_valid), .out_x(v1_x), .out_y(v1_y), .out_ang(v1_ang),
    .out_side(v1_side)
  );

  // elevation and slant range
  logic            v2_valid;
  nbaer_pkg::vec_t v2_x, v2_y;
  nbaer_pkg::ang_t v2_ang;
  nbaer_pkg::ang_t v2_side;

  nbaer_cordic #(.STAGES(CORDIC_STAGES), .VECTORING(1'b1), .SIDE_W(32)) u_vec_el (
    .clk(clk), .rst_n(rst_n), .in_valid(v1_valid),
    .in_x(v1_x), .in_y(-v1_side), .in_ang(32'h0), .in_side(v1_ang),
    .out_valid(v2_valid), .out_x(v2_x), .out_y(v2_y), .out_ang(v2_ang),
    .out_side(v2_side)
  );

  // output formatting
  nbaer_pkg::ang_t     az_rnd;
  logic signed [32:0]  el_sum;
  logic signed [16:0]  el_q;
  logic signed [15:0]  el_nxt;
  nbaer_pkg::vec_t     rng_q;
  logic [33:0]         rng_nxt;

  always_comb begin
    az_rnd = v2_side + 32'h0000_8000;
    el_sum = $signed({v2_ang[31], v2_ang}) + 33'sh0_8000;
    el_q   = el_sum[32:16];
    if (el_q > 17'sd16384) begin
      el_nxt = 16'sd16384;
    end else if (el_q < -17'sd16384) begin
      el_nxt = -16'sd16384;
    end else begin
      el_nxt = el_q[15:0];
    end
    rng_q = (v2_x + W'(8)) >>> nbaer_pkg::GUARD;
    if (rng_q[W-1]) begin
      rng_nxt = '0;
    end else if (rng_q[W-2:34] != '0) begin
      rng_nxt = '1;
    end else begin
      rng_nxt = rng_q[33:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2_valid;
    end
    out_azimuth     <= az_rnd[31:16];
    out_elevation   <= el_nxt;
    out_slant_range <= rng_nxt;
  end

endmodule
